>>> rtl/fpa_pkg.sv
// types, constants and saturation helpers for the q24.8 fixed-point alu
// no dependencies
package fpa_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_BITS = 8;
    localparam int NUM_W = DATA_W + FRAC_BITS;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_GE, OP_LE,
        OP_EQ, OP_NE, OP_MIN, OP_MAX, OP_INC, OP_DEC, OP_TO_INT, OP_FROM_INT
    } t_op;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_DIV_ZERO = 2'd2
    } t_status;

    typedef struct packed {
        logic [3:0]               operation;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     compare_true;
        logic [1:0]               status_code;
    } t_out;

    // control and finished results that ride along the divider stages
    typedef struct packed {
        logic  valid;
        logic  is_div;
        logic  neg;
        logic  dz;
        t_out  res;
    } t_side;

    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [NUM_W-1:0]  quo;
        logic [NUM_W-1:0]  num;
        logic [DATA_W-1:0] den;
    } t_div;

    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    // clamp a wide signed value to the 32-bit range
    function automatic t_out sat_s(input logic signed [63:0] v);
        t_out r;
        r = '0;
        if (v > SAT_HI) begin
            r.result_value = SAT_HI[DATA_W-1:0];
            r.status_code = ST_OVERFLOW;
        end else if (v < SAT_LO) begin
            r.result_value = SAT_LO[DATA_W-1:0];
            r.status_code = ST_OVERFLOW;
        end else begin
            r.result_value = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // clamp a magnitude with a sign to the 32-bit range
    function automatic t_out sat_mag(input logic [63:0] m, input logic neg);
        t_out r;
        logic [DATA_W-1:0] low;
        r = '0;
        low = m[DATA_W-1:0];
        if (!neg && m > 64'h7FFF_FFFF) begin
            r.result_value = SAT_HI[DATA_W-1:0];
            r.status_code = ST_OVERFLOW;
        end else if (neg && m > 64'h8000_0000) begin
            r.result_value = SAT_LO[DATA_W-1:0];
            r.status_code = ST_OVERFLOW;
        end else begin
            r.result_value = neg ? (~low + 1'b1) : low;
        end
        return r;
    endfunction

endpackage

>>> rtl/fpa_div_step.sv
// one registered step of the restoring divider, one quotient bit per stage
// depends on fpa_pkg
module fpa_div_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  fpa_pkg::t_side i_side,
    input  fpa_pkg::t_div  i_div,
    output fpa_pkg::t_side o_side,
    output fpa_pkg::t_div  o_div
);

    fpa_pkg::t_side r_side;
    fpa_pkg::t_div  r_div;
    fpa_pkg::t_div  n_div;
    logic [fpa_pkg::DATA_W:0] sh;

    always_comb begin
        sh = {i_div.rem, i_div.num[fpa_pkg::NUM_W-1]};
        n_div = i_div;
        n_div.num = {i_div.num[fpa_pkg::NUM_W-2:0], 1'b0};
        if (sh >= {1'b0, i_div.den}) begin
            n_div.rem = sh[fpa_pkg::DATA_W-1:0] - i_div.den;
            n_div.quo = {i_div.quo[fpa_pkg::NUM_W-2:0], 1'b1};
        end else begin
            n_div.rem = sh[fpa_pkg::DATA_W-1:0];
            n_div.quo = {i_div.quo[fpa_pkg::NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side.valid <= i_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side.is_div <= i_side.is_div;
            r_side.neg <= i_side.neg;
            r_side.dz <= i_side.dz;
            r_side.res <= i_side.res;
            r_div <= n_div;
        end
    end

    assign o_side = r_side;
    assign o_div = r_div;

endmodule

>>> rtl/fixed_point_alu_core.sv
// top level of the pipelined q24.8 fixed-point alu
// depends on fpa_pkg and fpa_div_step
//
//  channel | direction | handshake            | beat
//  --------+-----------+----------------------+--------------------------------
//  input   | in        | i_valid / o_stall    | i_data: operation, a, b
//  output  | out       | o_valid / i_stall    | o_data: value, compare, status
//
// one beat is accepted per cycle while o_stall is low; every beat passes through
// the stages in order (input register, operate, multiply round, 40 divider stages,
// output register). the 40-stage divider sets the latency for all operations
// so results stay in order. reset clears only the valid bits. when the output
// beat is held by i_stall the whole pipeline freezes and o_stall goes high.
module fixed_point_alu_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  fpa_pkg::t_in i_data,
    output logic         o_valid,
    input  logic         i_stall,
    output fpa_pkg::t_out o_data
);

    localparam int DW = fpa_pkg::DATA_W;
    localparam int FB = fpa_pkg::FRAC_BITS;
    localparam int NW = fpa_pkg::NUM_W;

    // global advance: pipeline moves unless the output beat is held
    logic en;
    assign en = !(o_valid && i_stall);
    assign o_stall = !en;

    // stage a: input register
    logic         r_a_valid;
    fpa_pkg::t_in r_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= i_data;
        end
    end

    // stage b: simple ops, raw product, divider setup
    logic signed [63:0]  a64, b64;
    logic [DW-1:0]       mag_a, mag_b;
    fpa_pkg::t_out       n_b_res;
    fpa_pkg::t_op        op;
    logic signed [DW-1:0] trunc_q;

    assign a64 = 64'(r_a.operand_a);
    assign b64 = 64'(r_a.operand_b);
    assign mag_a = r_a.operand_a[DW-1] ? (~r_a.operand_a + 1'b1) : r_a.operand_a;
    assign mag_b = r_a.operand_b[DW-1] ? (~r_a.operand_b + 1'b1) : r_a.operand_b;
    assign op = fpa_pkg::t_op'(r_a.operation);

    always_comb begin
        // to_int truncates toward zero: floor, then bump negatives with a fraction
        trunc_q = r_a.operand_a >>> FB;
        if (r_a.operand_a[DW-1] && (r_a.operand_a[FB-1:0] != '0)) begin
            trunc_q = trunc_q + 1'b1;
        end
        n_b_res = '0;
        case (op)
            fpa_pkg::OP_ADD:      n_b_res = fpa_pkg::sat_s(a64 + b64);
            fpa_pkg::OP_SUB:      n_b_res = fpa_pkg::sat_s(a64 - b64);
            fpa_pkg::OP_GT:       n_b_res.compare_true = (a64 > b64);
            fpa_pkg::OP_LT:       n_b_res.compare_true = (a64 < b64);
            fpa_pkg::OP_GE:       n_b_res.compare_true = (a64 >= b64);
            fpa_pkg::OP_LE:       n_b_res.compare_true = (a64 <= b64);
            fpa_pkg::OP_EQ:       n_b_res.compare_true = (a64 == b64);
            fpa_pkg::OP_NE:       n_b_res.compare_true = (a64 != b64);
            fpa_pkg::OP_MIN:      n_b_res.result_value = (a64 < b64) ? r_a.operand_a
                                                                     : r_a.operand_b;
            fpa_pkg::OP_MAX:      n_b_res.result_value = (a64 > b64) ? r_a.operand_a
                                                                     : r_a.operand_b;
            fpa_pkg::OP_INC:      n_b_res = fpa_pkg::sat_s(a64 + 64'sd1);
            fpa_pkg::OP_DEC:      n_b_res = fpa_pkg::sat_s(a64 - 64'sd1);
            fpa_pkg::OP_TO_INT:   n_b_res.result_value = trunc_q;
            fpa_pkg::OP_FROM_INT: n_b_res = fpa_pkg::sat_s(a64 <<< FB);
            default:              n_b_res = '0;  // mul and div finish later
        endcase
    end

    logic               r_b_valid;
    logic               r_b_is_mul, r_b_is_div, r_b_neg, r_b_dz;
    fpa_pkg::t_out      r_b_res;
    logic signed [63:0] r_b_prod;
    logic [NW-1:0]      r_b_num;
    logic [DW-1:0]      r_b_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_is_mul <= (op == fpa_pkg::OP_MUL);
            r_b_is_div <= (op == fpa_pkg::OP_DIV);
            r_b_neg <= r_a.operand_a[DW-1] ^ r_a.operand_b[DW-1];
            r_b_dz <= (r_a.operand_b == '0);
            r_b_res <= n_b_res;
            r_b_prod <= r_a.operand_a * r_a.operand_b;  // 32x32 signed
            r_b_num <= {mag_a, {FB{1'b0}}};
            r_b_den <= mag_b;
        end
    end

    // stage c: round the product half away from zero and saturate
    logic [63:0]    prod_mag, prod_rnd;
    fpa_pkg::t_side n_c_side;
    fpa_pkg::t_div  n_c_div;

    always_comb begin
        prod_mag = r_b_prod[63] ? (~r_b_prod + 1'b1) : r_b_prod;
        prod_rnd = (prod_mag + (64'd1 << (FB - 1))) >> FB;
        n_c_side.valid = r_b_valid;
        n_c_side.is_div = r_b_is_div;
        n_c_side.neg = r_b_neg;
        n_c_side.dz = r_b_dz;
        n_c_side.res = r_b_is_mul ? fpa_pkg::sat_mag(prod_rnd, r_b_prod[63]) : r_b_res;
        n_c_div.rem = '0;
        n_c_div.quo = '0;
        n_c_div.num = r_b_num;
        n_c_div.den = r_b_den;
    end

    fpa_pkg::t_side r_c_side;
    fpa_pkg::t_div  r_c_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_side.valid <= 1'b0;
        end else if (en) begin
            r_c_side.valid <= n_c_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_side.is_div <= n_c_side.is_div;
            r_c_side.neg <= n_c_side.neg;
            r_c_side.dz <= n_c_side.dz;
            r_c_side.res <= n_c_side.res;
            r_c_div <= n_c_div;
        end
    end

    // divider: one quotient bit per stage, everything else rides along
    fpa_pkg::t_side side_chain [0:NW];
    fpa_pkg::t_div  div_chain [0:NW];

    assign side_chain[0] = r_c_side;
    assign div_chain[0] = r_c_div;

    for (genvar k = 0; k < NW; k++) begin : g_div
        fpa_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_side  (side_chain[k]),
            .i_div   (div_chain[k]),
            .o_side  (side_chain[k+1]),
            .o_div   (div_chain[k+1])
        );
    end

    // final: round the quotient (twice the remainder against the divisor)
    fpa_pkg::t_side fin_side;
    fpa_pkg::t_div  fin_div;
    logic           q_up;
    logic [63:0]    q_rnd;
    fpa_pkg::t_out  n_out;

    assign fin_side = side_chain[NW];
    assign fin_div = div_chain[NW];

    always_comb begin
        q_up = ({fin_div.rem, 1'b0} >= {1'b0, fin_div.den});
        q_rnd = 64'(fin_div.quo) + 64'(q_up);
        n_out = fin_side.res;
        if (fin_side.is_div) begin
            if (fin_side.dz) begin
                n_out = '0;
                n_out.status_code = fpa_pkg::ST_DIV_ZERO;
            end else begin
                n_out = fpa_pkg::sat_mag(q_rnd, fin_side.neg);
            end
        end
    end

    // output register
    logic          r_out_valid;
    fpa_pkg::t_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= fin_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data = r_out;

endmodule

>>> dv/tb_fixed_point_alu_core.sv
`timescale 1ns / 100ps
// self-checking testbench for the q24.8 fixed-point alu core
// depends on fpa_pkg and the fixed_point_alu_core rtl
module tb_fixed_point_alu_core;

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    // block ports
    logic          i_valid = 1'b0;
    logic          o_stall;
    fpa_pkg::t_in  i_data = '0;
    logic          o_valid;
    logic          i_stall = 1'b1;
    fpa_pkg::t_out o_data;

    fixed_point_alu_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    // pending results, oldest first
    fpa_pkg::t_out alu_results_q[$];
    int   mismatch_cnt = 0;
    int   cycle_cnt = 0;
    int   sender_idle_pct = 14;
    int   receiver_idle_pct = 54;
    bit   hold_receiver = 1'b0;
    bit   stim_done = 1'b0;

    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -64'sd2147483648;
    localparam int     ROWS = 24;
    localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
    localparam logic [31:0] MINN = 32'h8000_0000;

    // clamp a wide value to the signed word range and flag overflow
    function automatic fpa_pkg::t_out clamp_word(input longint v);
        fpa_pkg::t_out r;
        r = '0;
        if (v > Q_HI) begin
            r.result_value = MAXP;
            r.status_code = fpa_pkg::ST_OVERFLOW;
        end else if (v < Q_LO) begin
            r.result_value = MINN;
            r.status_code = fpa_pkg::ST_OVERFLOW;
        end else begin
            r.result_value = v[31:0];
        end
        return r;
    endfunction

    // exact fixed-point behavior of one operation
    function automatic fpa_pkg::t_out alu_predict(input fpa_pkg::t_in b);
        fpa_pkg::t_out r;
        longint a;
        longint c;
        longint p;
        longint m;
        longint n;
        longint d;
        longint q;
        fpa_pkg::t_op op;
        r = '0;
        a = longint'(b.operand_a);
        c = longint'(b.operand_b);
        op = fpa_pkg::t_op'(b.operation);
        case (op)
            fpa_pkg::OP_ADD: r = clamp_word(a + c);
            fpa_pkg::OP_SUB: r = clamp_word(a - c);
            fpa_pkg::OP_MUL: begin
                p = a * c;
                m = ((p < 0 ? -p : p) + (64'sd1 <<< (fpa_pkg::FRAC_BITS - 1)))
                    >>> fpa_pkg::FRAC_BITS;
                r = clamp_word(p < 0 ? -m : m);
            end
            fpa_pkg::OP_DIV: begin
                if (c == 0) begin
                    r.status_code = fpa_pkg::ST_DIV_ZERO;
                end else begin
                    n = (a < 0 ? -a : a) <<< fpa_pkg::FRAC_BITS;
                    d = c < 0 ? -c : c;
                    q = (2 * n + d) / (2 * d);
                    r = clamp_word(((a < 0) != (c < 0)) ? -q : q);
                end
            end
            fpa_pkg::OP_GT: r.compare_true = a > c;
            fpa_pkg::OP_LT: r.compare_true = a < c;
            fpa_pkg::OP_GE: r.compare_true = a >= c;
            fpa_pkg::OP_LE: r.compare_true = a <= c;
            fpa_pkg::OP_EQ: r.compare_true = a == c;
            fpa_pkg::OP_NE: r.compare_true = a != c;
            fpa_pkg::OP_MIN: r.result_value = (a < c) ? b.operand_a : b.operand_b;
            fpa_pkg::OP_MAX: r.result_value = (a > c) ? b.operand_a : b.operand_b;
            fpa_pkg::OP_INC: r = clamp_word(a + 1);
            fpa_pkg::OP_DEC: r = clamp_word(a - 1);
            fpa_pkg::OP_TO_INT: begin
                q = a / (64'sd1 <<< fpa_pkg::FRAC_BITS);   // truncates toward zero
                r.result_value = q[31:0];
            end
            default: r = clamp_word(a * (64'sd1 <<< fpa_pkg::FRAC_BITS));
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_cnt);
        mismatch_cnt++;
    endtask

    // directed table: operation, a, b, typed expectation where obvious
    typedef struct {
        fpa_pkg::t_op  op;
        logic [31:0]   a;
        logic [31:0]   b;
        bit            typed;
        fpa_pkg::t_out want;
    } t_row;
    t_row dir_table[ROWS];

    initial begin
        dir_table[0]  = '{fpa_pkg::OP_ADD, MAXP, 32'h1, 1'b1,
                          '{MAXP, 1'b0, fpa_pkg::ST_OVERFLOW}};
        dir_table[1]  = '{fpa_pkg::OP_SUB, MINN, 32'h1, 1'b1,
                          '{MINN, 1'b0, fpa_pkg::ST_OVERFLOW}};
        dir_table[2]  = '{fpa_pkg::OP_MUL, MAXP, MAXP, 1'b1,
                          '{MAXP, 1'b0, fpa_pkg::ST_OVERFLOW}};
        dir_table[3]  = '{fpa_pkg::OP_MUL, MINN, MAXP, 1'b1,
                          '{MINN, 1'b0, fpa_pkg::ST_OVERFLOW}};
        dir_table[4]  = '{fpa_pkg::OP_MUL, 32'hFFFF_FF80, 32'h1, 1'b0, '0};  // half rounds away
        dir_table[5]  = '{fpa_pkg::OP_DIV, 32'h100, 32'h0, 1'b1,
                          '{32'h0, 1'b0, fpa_pkg::ST_DIV_ZERO}};
        dir_table[6]  = '{fpa_pkg::OP_DIV, 32'h0, 32'h0, 1'b1,
                          '{32'h0, 1'b0, fpa_pkg::ST_DIV_ZERO}};
        dir_table[7]  = '{fpa_pkg::OP_DIV, MINN, 32'h1, 1'b1,
                          '{MINN, 1'b0, fpa_pkg::ST_OVERFLOW}};
        dir_table[8]  = '{fpa_pkg::OP_DIV, 32'h1, 32'hFFFF_FFFD, 1'b0, '0};
        dir_table[9]  = '{fpa_pkg::OP_GT, MAXP, MINN, 1'b1,
                          '{32'h0, 1'b1, fpa_pkg::ST_OK}};
        dir_table[10] = '{fpa_pkg::OP_LT, MAXP, MINN, 1'b1,
                          '{32'h0, 1'b0, fpa_pkg::ST_OK}};
        dir_table[11] = '{fpa_pkg::OP_GE, 32'h5, 32'h5, 1'b1,
                          '{32'h0, 1'b1, fpa_pkg::ST_OK}};
        dir_table[12] = '{fpa_pkg::OP_LE, MINN, MINN, 1'b1,
                          '{32'h0, 1'b1, fpa_pkg::ST_OK}};
        dir_table[13] = '{fpa_pkg::OP_EQ, 32'h7, 32'h8, 1'b1,
                          '{32'h0, 1'b0, fpa_pkg::ST_OK}};
        dir_table[14] = '{fpa_pkg::OP_NE, 32'h7, 32'h8, 1'b1,
                          '{32'h0, 1'b1, fpa_pkg::ST_OK}};
        dir_table[15] = '{fpa_pkg::OP_MIN, MINN, MAXP, 1'b1,
                          '{MINN, 1'b0, fpa_pkg::ST_OK}};
        dir_table[16] = '{fpa_pkg::OP_MAX, MINN, MAXP, 1'b1,
                          '{MAXP, 1'b0, fpa_pkg::ST_OK}};
        dir_table[17] = '{fpa_pkg::OP_INC, MAXP, 32'h0, 1'b1,
                          '{MAXP, 1'b0, fpa_pkg::ST_OVERFLOW}};
        dir_table[18] = '{fpa_pkg::OP_DEC, MINN, 32'h0, 1'b1,
                          '{MINN, 1'b0, fpa_pkg::ST_OVERFLOW}};
        dir_table[19] = '{fpa_pkg::OP_TO_INT, 32'hFFFF_FE80, 32'h0, 1'b1,
                          '{32'hFFFF_FFFF, 1'b0, fpa_pkg::ST_OK}};
        dir_table[20] = '{fpa_pkg::OP_TO_INT, MINN, 32'h0, 1'b0, '0};
        dir_table[21] = '{fpa_pkg::OP_FROM_INT, 32'h0080_0000, 32'h0, 1'b1,
                          '{MAXP, 1'b0, fpa_pkg::ST_OVERFLOW}};
        dir_table[22] = '{fpa_pkg::OP_FROM_INT, 32'hFF80_0000, 32'h0, 1'b1,
                          '{MINN, 1'b0, fpa_pkg::ST_OK}};
        dir_table[23] = '{fpa_pkg::OP_MIN, 32'h3, 32'h3, 1'b0, '0};
    end

    // random operand with a bias toward edges and small values
    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return MAXP;
            1: return MINN;
            2: return 32'($signed($urandom_range(0, 1024)) - 512);
            3: return {{8{1'b0}}, 24'($urandom)};
            4: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    // drive one beat and hold it until accepted
    task automatic send_beat(input fpa_pkg::t_in b);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        alu_results_q.push_back(alu_predict(b));
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b1;
        end else begin
            i_stall <= hold_receiver || ($urandom_range(0, 99) < receiver_idle_pct);
        end
    end

    // output checker
    always @(posedge i_clk) begin
        fpa_pkg::t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (alu_results_q.size() == 0) begin
                report_mismatch("unexpected beat", o_data.result_value, 32'h0);
            end else begin
                want = alu_results_q.pop_front();
                if (o_data.result_value !== want.result_value)
                    report_mismatch("result_value", o_data.result_value, want.result_value);
                if (o_data.compare_true !== want.compare_true)
                    report_mismatch("compare_true", 32'(o_data.compare_true),
                                    32'(want.compare_true));
                if (o_data.status_code !== want.status_code)
                    report_mismatch("status_code", 32'(o_data.status_code),
                                    32'(want.status_code));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 200000) begin
            $display("fixed_point_alu_core verification failed");
            $finish;
        end
    end

    // long receiver hold-off while the sender keeps offering beats
    initial begin
        wait (stim_done == 1'b0 && i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_receiver = 1'b1;
        repeat (150) @(posedge i_clk);
        hold_receiver = 1'b0;
    end

    // stimulus
    initial begin
        fpa_pkg::t_in  b;
        fpa_pkg::t_out typed_want;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, typed rows checked against the predictor as well
        for (int k = 0; k < ROWS; k++) begin
            b.operation = dir_table[k].op;
            b.operand_a = dir_table[k].a;
            b.operand_b = dir_table[k].b;
            if (dir_table[k].typed) begin
                typed_want = alu_predict(b);
                if (typed_want !== dir_table[k].want)
                    report_mismatch("table row", typed_want.result_value,
                                    dir_table[k].want.result_value);
            end
            send_beat(b);
        end

        // sender pauses until everything has drained
        i_valid <= 1'b0;
        while (alu_results_q.size() != 0) @(posedge i_clk);

        // random phases with swapped idle rates, then a last phase with no idle at all
        for (int ph = 0; ph < 3; ph++) begin
            sender_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 54 : 0;
            receiver_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 14 : 0;
            for (int k = 0; k < 270; k++) begin
                b.operation = 4'($urandom_range(0, 15));
                b.operand_a = rand_operand();
                b.operand_b = ($urandom_range(0, 9) == 0) ? b.operand_a : rand_operand();
                send_beat(b);
            end
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;

        while (alu_results_q.size() != 0) @(posedge i_clk);
        repeat (fpa_pkg::NUM_W + 20) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("fixed_point_alu_core verification clean");
        end else begin
            $display("fixed_point_alu_core verification failed");
        end
        $finish;
    end

endmodule
